### src/jsu_pkg.sv
// Shared types and constants for the JSON string unescape unit.
// Holds the command record that the front hands to the back and the result kinds.
// Depends on nothing.
`default_nettype none

package jsu_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [7:0] CH_NUL       = 8'h00;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_U         = 8'h75;

	// One command is everything one accepted byte produces, in order:
	// an optional held surrogate, an optional code point, an optional end or error.
	typedef struct packed {
		logic        flush_en;
		logic [15:0] flush_cp;
		logic        cp_en;
		logic [20:0] cp;
		logic        term_en;
		logic [1:0]  term_kind;
	} cmd_t;

endpackage

`default_nettype wire

### src/jsu_front.sv
// Front of the JSON string unescape unit: parses escapes and surrogate pairs.
// Turns each accepted byte into at most one command for the queue. Uses jsu_pkg.
`default_nettype none

module jsu_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               byte_valid,
	input  wire  [7:0]        in_byte,
	output logic              byte_stall,
	input  wire               full,
	output logic              push,
	output jsu_pkg::cmd_t     cmd
);
	import jsu_pkg::*;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_BODY     = 3'd1;
	localparam logic [2:0] PH_ESC      = 3'd2;
	localparam logic [2:0] PH_HEX      = 3'd3;
	localparam logic [2:0] PH_HELD     = 3'd4;
	localparam logic [2:0] PH_HELD_ESC = 3'd5;

	logic [2:0]  phase_q, phase_d;
	logic [15:0] hex_q, hex_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [15:0] held_q, held_d;
	logic        held_v_q, held_v_d;

	logic        accept;
	logic        finish_c;
	logic        dig_ok;
	logic [3:0]  dig;
	logic        esc_ok;
	logic [7:0]  esc_byte;
	logic [15:0] acc;
	logic [20:0] joined;

	always_comb begin
		dig_ok = 1'b1;
		dig = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			dig = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			dig = 4'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			dig = 4'(in_byte - 8'h37);
		end else begin
			dig_ok = 1'b0;
		end
	end

	always_comb begin
		esc_ok = 1'b1;
		case (in_byte)
			8'h22: esc_byte = 8'h22;
			8'h5C: esc_byte = 8'h5C;
			8'h2F: esc_byte = 8'h2F;
			8'h62: esc_byte = 8'h08;
			8'h66: esc_byte = 8'h0C;
			8'h6E: esc_byte = 8'h0A;
			8'h72: esc_byte = 8'h0D;
			8'h74: esc_byte = 8'h09;
			default: begin
				esc_ok = 1'b0;
				esc_byte = 8'h00;
			end
		endcase
	end

	assign acc = {hex_q[11:0], dig};
	assign joined = 21'h10000 + {1'b0, held_q[9:0], acc[9:0]};

	always_comb begin
		phase_d = phase_q;
		hex_d = hex_q;
		cnt_d = cnt_q;
		held_d = held_q;
		held_v_d = held_v_q;
		cmd = '0;
		finish_c = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (in_byte == CH_QUOTE) begin
					phase_d = PH_BODY;
				end else begin
					finish_c = 1'b1;
					cmd.term_kind = KIND_ERR;
				end
			end
			PH_BODY: begin
				if (in_byte == CH_NUL) begin
					finish_c = 1'b1;
					cmd.term_kind = KIND_ERR;
				end else if (in_byte == CH_QUOTE) begin
					finish_c = 1'b1;
					cmd.term_kind = KIND_END;
				end else if (in_byte == CH_BACKSLASH) begin
					phase_d = PH_ESC;
				end else begin
					cmd.cp_en = 1'b1;
					cmd.cp = {13'd0, in_byte};
				end
			end
			PH_ESC, PH_HELD_ESC: begin
				if (in_byte == CH_U) begin
					hex_d = '0;
					cnt_d = '0;
					phase_d = PH_HEX;
				end else if (!esc_ok) begin
					finish_c = 1'b1;
					cmd.term_kind = KIND_ERR;
				end else begin
					cmd.flush_en = held_v_q;
					cmd.flush_cp = held_q;
					held_d = '0;
					held_v_d = 1'b0;
					cmd.cp_en = 1'b1;
					cmd.cp = {13'd0, esc_byte};
					phase_d = PH_BODY;
				end
			end
			PH_HEX: begin
				if (!dig_ok) begin
					finish_c = 1'b1;
					cmd.term_kind = KIND_ERR;
				end else if (cnt_q != 2'd3) begin
					hex_d = acc;
					cnt_d = cnt_q + 2'd1;
				end else begin
					hex_d = '0;
					cnt_d = '0;
					held_d = '0;
					held_v_d = 1'b0;
					if (held_v_q && acc >= 16'hDC00 && acc <= 16'hDFFF) begin
						cmd.cp_en = 1'b1;
						cmd.cp = joined;
						phase_d = PH_BODY;
					end else begin
						cmd.flush_en = held_v_q;
						cmd.flush_cp = held_q;
						if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
							held_d = acc;
							held_v_d = 1'b1;
							phase_d = PH_HELD;
						end else begin
							cmd.cp_en = 1'b1;
							cmd.cp = {5'd0, acc};
							phase_d = PH_BODY;
						end
					end
				end
			end
			PH_HELD: begin
				if (in_byte == CH_BACKSLASH) begin
					phase_d = PH_HELD_ESC;
				end else if (in_byte == CH_NUL) begin
					finish_c = 1'b1;
					cmd.term_kind = KIND_ERR;
				end else begin
					cmd.flush_en = held_v_q;
					cmd.flush_cp = held_q;
					held_d = '0;
					held_v_d = 1'b0;
					if (in_byte == CH_QUOTE) begin
						finish_c = 1'b1;
						cmd.term_kind = KIND_END;
					end else begin
						cmd.cp_en = 1'b1;
						cmd.cp = {13'd0, in_byte};
					end
				end
			end
			default: begin
				finish_c = 1'b1;
				cmd.term_kind = KIND_ERR;
			end
		endcase
		if (finish_c) begin
			cmd.term_en = 1'b1;
			phase_d = PH_IDLE;
			hex_d = '0;
			cnt_d = '0;
			held_d = '0;
			held_v_d = 1'b0;
		end
	end

	assign byte_stall = full;
	assign accept = byte_valid && !full;
	assign push = accept && (cmd.flush_en || cmd.cp_en || cmd.term_en);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hex_q <= '0;
			cnt_q <= '0;
			held_q <= '0;
			held_v_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			hex_q <= hex_d;
			cnt_q <= cnt_d;
			held_q <= held_d;
			held_v_q <= held_v_d;
		end
	end

endmodule

`default_nettype wire

### src/jsu_queue.sv
// Command queue between the front and the back of the unescape unit.
// A small register FIFO with a full flag and a head output. Uses jsu_pkg.
`default_nettype none

module jsu_queue #(
	parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  jsu_pkg::cmd_t     push_cmd,
	input  wire               pop,
	output logic              full,
	output logic              nonempty,
	output jsu_pkg::cmd_t     head
);
	import jsu_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && nonempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### src/jsu_back.sv
// Back of the unescape unit: expands each command into UTF-8 bytes and end or error items.
// Emits one result per cycle while a command is queued and res_stall is low, through an output register. Uses jsu_pkg.
`default_nettype none

module jsu_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               nonempty,
	input  jsu_pkg::cmd_t     head,
	output logic              pop,
	output logic              res_valid,
	input  wire               res_stall,
	output logic [7:0]        out_byte,
	output logic [1:0]        kind,
	output logic              last
);
	import jsu_pkg::*;

	logic [2:0] idx_q;
	logic [2:0] cp_len, fl_n, cp_n, total, j;
	logic [7:0] byte_c;
	logic [1:0] kind_c;
	logic       last_c;
	logic       advance;
	logic       res_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] kind_q;
	logic       last_q;

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
		input logic [2:0] pos);
		logic [7:0] b;
		b = 8'h00;
		case (len)
			3'd1: b = cp[7:0];
			3'd2: b = (pos == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			3'd3: begin
				case (pos)
					3'd0: b = {4'b1110, cp[15:12]};
					3'd1: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (pos)
					3'd0: b = {5'b11110, cp[20:18]};
					3'd1: b = {2'b10, cp[17:12]};
					3'd2: b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

	always_comb begin
		if (head.cp < 21'h80) begin
			cp_len = 3'd1;
		end else if (head.cp < 21'h800) begin
			cp_len = 3'd2;
		end else if (head.cp < 21'h10000) begin
			cp_len = 3'd3;
		end else begin
			cp_len = 3'd4;
		end
	end

	assign fl_n = head.flush_en ? 3'd3 : 3'd0;
	assign cp_n = head.cp_en ? cp_len : 3'd0;
	assign total = fl_n + cp_n + {2'd0, head.term_en};
	assign j = idx_q - fl_n;

	always_comb begin
		kind_c = KIND_DATA;
		if (idx_q < fl_n) begin
			byte_c = utf8_byte({5'd0, head.flush_cp}, 3'd3, idx_q);
		end else if (j < cp_n) begin
			byte_c = utf8_byte(head.cp, cp_len, j);
		end else begin
			byte_c = 8'h00;
			kind_c = head.term_kind;
		end
	end

	assign last_c = (idx_q == total - 3'd1);
	assign advance = nonempty && (!res_valid_q || !res_stall);
	assign pop = advance && last_c;

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_c;
			kind_q <= kind_c;
			last_q <= last_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (!res_valid_q || !res_stall) begin
				res_valid_q <= nonempty;
			end
			if (advance) begin
				idx_q <= last_c ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign out_byte = out_byte_q;
	assign kind = kind_q;
	assign last = last_q;

endmodule

`default_nettype wire

### src/json_string_unescape_utf8_unit.sv
// Top level of the JSON string unescape unit: front parser, command queue, UTF-8 back end.
// Path: the results of an accepted byte pass through the queue and then the output register.
// Throughput: one input byte per cycle while each byte yields at most one result and res_stall is low;
// a byte that yields several results holds the back end until all are out, and the queue absorbs the burst.
// Reset: arst_n clears the parser state, the queue and the output valid flag at once.
`default_nettype none

module json_string_unescape_utf8_unit #(
	parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        byte_valid,
	output logic       byte_stall,
	input  wire  [7:0] in_byte,
	output logic       res_valid,
	input  wire        res_stall,
	output logic [7:0] out_byte,
	output logic [1:0] kind,
	output logic       last
);
	import jsu_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic push;
	logic pop;
	logic full;
	logic nonempty;

	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.in_byte    (in_byte),
		.byte_stall (byte_stall),
		.full       (full),
		.push       (push),
		.cmd        (front_cmd)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.head     (head_cmd)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.nonempty  (nonempty),
		.head      (head_cmd),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.out_byte  (out_byte),
		.kind      (kind),
		.last      (last)
	);

endmodule

`default_nettype wire

### src/jsu_checker.sv
// Port-level assertions for the JSON string unescape unit, bound to its top level.
// Uses jsu_pkg for the result kinds.
`default_nettype none

module jsu_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       res_valid,
	input wire       res_stall,
	input wire [7:0] out_byte,
	input wire [1:0] kind,
	input wire       last
);
	import jsu_pkg::*;

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (kind == KIND_DATA || kind == KIND_END || kind == KIND_ERR))
		else $error("result kind out of range");

	a_term_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind != KIND_DATA) |-> (last && out_byte == 8'h00))
		else $error("end or error transaction is not a final zero result");

	a_lead_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind == KIND_DATA && out_byte[7:6] == 2'b11) |-> !last)
		else $error("UTF-8 lead byte marked as final result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=>
		(res_valid && $stable(out_byte) && $stable(kind) && $stable(last)))
		else $error("stalled result transaction changed");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.out_byte  (out_byte),
	.kind      (kind),
	.last      (last)
);

`default_nettype wire
